/* design/signed_int_to_decimal_ascii_macros.svh */
// Assertion macros for the design files; only sidta_back includes them.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SIDTA_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SIDTA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/sidta_pkg.sv */
package sidta_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int CHAR_W         = 8;
  localparam int COUNT_W        = 31;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SIGN,
    B_DIGIT
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

/* design/signed_int_to_decimal_ascii.sv */
// An accepted value is converted and pushed into the queue; the back end then pops it and sends
// its characters one per cycle while out_ready is high.
// Conversion uses the binary to BCD shift-add loop, which retires two magnitude bits per cycle; the
// front end takes no new value until the last one is pushed, and a two-entry queue lets character
// output overlap the next conversion.
// Reset: synchronous, active low; clears control state, the queue and the character total.
module signed_int_to_decimal_ascii import sidta_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [CHAR_W-1:0]            out_character,
  output logic                         out_last_char,
  output logic [COUNT_W-1:0]           out_total_count
);

  localparam int DIGITS  = (VALUE_BITS * 3) / 10 + 1;
  localparam int ENTRY_W = 1 + $clog2(DIGITS) + DIGITS * 4;

  qstat_t               qs;
  logic                 push;
  logic                 pop;
  logic [ENTRY_W-1:0]   push_data;
  logic [ENTRY_W-1:0]   pop_data;

  sidta_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_value (in_value),
    .qs       (qs),
    .push     (push),
    .push_data(push_data)
  );

  sidta_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .qs       (qs)
  );

  sidta_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .qs             (qs),
    .pop            (pop),
    .pop_data       (pop_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_character  (out_character),
    .out_last_char  (out_last_char),
    .out_total_count(out_total_count)
  );

endmodule

/* design/sidta_front.sv */
module sidta_front import sidta_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  qstat_t                       qs,
  output logic                         push,
  output logic [((VALUE_BITS*3)/10+1)*4+$clog2((VALUE_BITS*3)/10+1):0] push_data
);

  localparam int DIGITS = (VALUE_BITS * 3) / 10 + 1;
  localparam int BCD_W  = DIGITS * 4;
  localparam int IDX_W  = $clog2(DIGITS);
  localparam int MAG_W  = VALUE_BITS + (VALUE_BITS % 2);
  localparam int STEPS  = MAG_W / 2;
  localparam int STEP_W = $clog2(STEPS);

  front_state_t      state_r, state_nxt;
  logic              neg_r, neg_nxt;
  logic [MAG_W-1:0]  mag_r, mag_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [VALUE_BITS-1:0] in_u, mag_in;
  logic [BCD_W-1:0]  bcd_one;
  logic [IDX_W-1:0]  msd_idx;
  logic              accept;

  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b, input logic din);
    logic [BCD_W-1:0] a;
    a = b;
    for (int k = 0; k < DIGITS; k++) begin
      if (a[4*k +: 4] >= 4'd5) begin
        a[4*k +: 4] = a[4*k +: 4] + 4'd3;
      end
    end
    return {a[BCD_W-2:0], din};
  endfunction

  assign accept = in_valid && in_ready;
  assign in_u   = $unsigned(in_value);
  assign mag_in = in_u[VALUE_BITS-1] ? (~in_u) + {{(VALUE_BITS-1){1'b0}}, 1'b1} : in_u;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          state_nxt = F_CONV;
        end
      end
      F_CONV: begin
        if (step_r == '0) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!qs.full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    push     = 1'b0;
    unique case (state_r)
      F_IDLE:  in_ready = 1'b1;
      F_CONV:  ;
      F_PUSH:  push = !qs.full;
      default: ;
    endcase
  end

  assign bcd_one = dabble(bcd_r, mag_r[MAG_W-1]);

  always_comb begin
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    step_nxt = step_r;
    if (accept) begin
      neg_nxt  = in_u[VALUE_BITS-1];
      mag_nxt  = MAG_W'(mag_in);
      bcd_nxt  = '0;
      step_nxt = STEP_W'(STEPS - 1);
    end else if (state_r == F_CONV) begin
      bcd_nxt  = dabble(bcd_one, mag_r[MAG_W-2]);
      mag_nxt  = {mag_r[MAG_W-3:0], 2'b00};
      step_nxt = step_r - 1'b1;
    end
  end

  always_comb begin
    msd_idx = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) begin
        msd_idx = IDX_W'(i);
      end
    end
  end

  assign push_data = {neg_r, msd_idx, bcd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    mag_r  <= mag_nxt;
    bcd_r  <= bcd_nxt;
    step_r <= step_nxt;
  end

endmodule

/* design/sidta_fifo.sv */
module sidta_fifo import sidta_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output qstat_t           qs
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign qs.full  = (cnt_r == CNT_W'(DEPTH));
  assign qs.empty = (cnt_r == '0);
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* design/sidta_back.sv */
module sidta_back import sidta_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  qstat_t             qs,
  output logic               pop,
  input  logic [((VALUE_BITS*3)/10+1)*4+$clog2((VALUE_BITS*3)/10+1):0] pop_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAR_W-1:0]  out_character,
  output logic               out_last_char,
  output logic [COUNT_W-1:0] out_total_count
);

  `include "signed_int_to_decimal_ascii_macros.svh"

  localparam int DIGITS = (VALUE_BITS * 3) / 10 + 1;
  localparam int BCD_W  = DIGITS * 4;
  localparam int IDX_W  = $clog2(DIGITS);

  back_state_t              state_r, state_nxt;
  logic [DIGITS-1:0][3:0]   bcd_r, bcd_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]        char_r, char_nxt;
  logic                     last_r, last_nxt;
  logic [COUNT_W-1:0]       total_r, total_nxt;
  logic                     out_free;
  logic                     emit;
  logic [CHAR_W-1:0]        emit_char;
  logic                     emit_last;
  logic                     pop_neg;

  assign out_free = !out_valid_r || out_ready;
  assign pop_neg  = pop_data[BCD_W + IDX_W];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!qs.empty) begin
          state_nxt = pop_neg ? B_SIGN : B_DIGIT;
        end
      end
      B_SIGN: begin
        if (out_free) begin
          state_nxt = B_DIGIT;
        end
      end
      B_DIGIT: begin
        if (out_free && (idx_r == '0)) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    emit      = 1'b0;
    emit_char = CHAR_ZERO + {4'b0000, bcd_r[idx_r]};
    emit_last = 1'b0;
    unique case (state_r)
      B_IDLE: pop = !qs.empty;
      B_SIGN: begin
        emit      = out_free;
        emit_char = CHAR_MINUS;
      end
      B_DIGIT: begin
        emit      = out_free;
        emit_last = (idx_r == '0);
      end
      default: ;
    endcase
  end

  always_comb begin
    bcd_nxt       = bcd_r;
    idx_nxt       = idx_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (pop) begin
      bcd_nxt = pop_data[BCD_W-1:0];
      idx_nxt = pop_data[BCD_W +: IDX_W];
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      char_nxt      = emit_char;
      last_nxt      = emit_last;
      if (total_r != COUNT_MAX) begin
        total_nxt = total_r + 1'b1;
      end
      if (state_r == B_DIGIT && idx_r != '0) begin
        idx_nxt = idx_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bcd_r  <= bcd_nxt;
    idx_r  <= idx_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_character   = char_r;
  assign out_last_char   = last_r;
  assign out_total_count = total_r;

  `SIDTA_ASSERT_NOW(a_minus_not_last, out_valid_r && (char_r == CHAR_MINUS), !last_r, "minus sign marked as last character")
  `SIDTA_ASSERT_NOW(a_char_range, out_valid_r && (char_r != CHAR_MINUS), (char_r >= CHAR_ZERO) && (char_r <= CHAR_ZERO + 8'd9), "character is neither a digit nor a minus sign")
  `SIDTA_ASSERT_NOW(a_total_nonzero, out_valid_r, total_r != '0, "valid character with zero total count")
  `SIDTA_ASSERT_NEXT(a_sign_then_digit, emit && (state_r == B_SIGN), (state_r == B_DIGIT) && out_valid_r && (char_r == CHAR_MINUS), "minus sign not followed by digit phase")
  `SIDTA_ASSERT_NEXT(a_total_step, emit && (total_r != COUNT_MAX), total_r == $past(total_r) + 1'b1, "total count did not advance by one")

endmodule
